@@ sv/assert_macros.svh @@
// Assertion macros shared by the RTL of the matrix engine.
// No dependencies; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must never hold while out of reset
`define MABT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("never violated");

// antecedent implies consequent in the same cycle
`define MABT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication violated");

// antecedent implies consequent in the next cycle
`define MABT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication violated");

`endif

@@ sv/mabt_pkg.sv @@
// Package for the matrix engine: constants, command codes, cell control type.
// No dependencies.
`default_nettype none
package mabt_pkg;
  localparam int MAX_N_DEF        = 16;
  localparam int ELEMENT_BITS_DEF = 16;
  localparam int ELEM_W           = 16;  // element port width
  localparam int SIZE_W           = 5;   // size register port width
  localparam int RES_W            = 64;  // result width

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // control broadcast to every cell of the chain
  typedef struct packed {
    logic shift_y;    // take operand from lower neighbour
    logic mul;        // form product
    logic shl;        // align product by the fraction bits
    logic clr;        // clear accumulator
    logic shift_acc;  // take accumulator from upper neighbour
  } cell_ctl_t;
endpackage
`default_nettype wire

@@ sv/mabt_if.sv @@
// Handshake channels of the matrix engine: request in, result out, size write.
// Depends on mabt_pkg.
`default_nettype none
interface mabt_in_if;
  import mabt_pkg::*;
  logic              valid;
  logic              ready;
  logic              command;
  logic [ELEM_W-1:0] a_element;
  logic [ELEM_W-1:0] b_element;
  modport source (output valid, command, a_element, b_element, input ready);
  modport sink   (input valid, command, a_element, b_element, output ready);
endinterface

interface mabt_out_if;
  import mabt_pkg::*;
  logic             valid;
  logic             ready;
  logic [RES_W-1:0] result_value;
  logic             last_element;
  logic             no_data;
  modport source (output valid, result_value, last_element, no_data, input ready);
  modport sink   (input valid, result_value, last_element, no_data, output ready);
endinterface

interface mabt_cfg_if;
  import mabt_pkg::*;
  logic              valid;
  logic              ready;
  logic [SIZE_W-1:0] size_n;
  modport source (output valid, size_n, input ready);
  modport sink   (input valid, size_n, output ready);
endinterface
`default_nettype wire

@@ sv/mabt_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none
module mabt_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ sv/mabt_cell.sv @@
// One multiply-accumulate cell of the chain: operand shift, product, accumulator.
// Depends on mabt_pkg.
`default_nettype none
module mabt_cell #(
  parameter int XW   = 36,
  parameter int YW   = 16,
  parameter int FRAC = 8
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire mabt_pkg::cell_ctl_t      ctl,
  input  wire logic signed [XW-1:0]     x,
  input  wire logic signed [YW-1:0]     y_in,
  output logic signed      [YW-1:0]     y_out,
  input  wire logic [mabt_pkg::RES_W-1:0] acc_in,
  output logic      [mabt_pkg::RES_W-1:0] acc_out
);
  import mabt_pkg::*;

  logic signed [YW-1:0]    y_r;
  logic signed [XW+YW-1:0] prod;
  logic [RES_W-1:0]        prod_r;
  logic [RES_W-1:0]        acc_r;
  logic                    add_pend_r;

  assign prod    = x * y_r;
  assign y_out   = y_r;
  assign acc_out = acc_r;

  // operand chain and product register
  always_ff @(posedge clk) begin
    if (ctl.shift_y) begin
      y_r <= y_in;
    end
    if (ctl.mul) begin
      prod_r <= ctl.shl ? (RES_W'(prod) << FRAC) : RES_W'(prod);
    end
  end

  // the add follows the product register load in the next cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      add_pend_r <= 1'b0;
    end else begin
      add_pend_r <= ctl.mul;
    end
  end

  // accumulator: clear, drain towards cell 0, or accumulate
  always_ff @(posedge clk) begin
    if (ctl.clr) begin
      acc_r <= '0;
    end else if (ctl.shift_acc) begin
      acc_r <= acc_in;
    end else if (add_pend_r) begin
      acc_r <= acc_r + prod_r;
    end
  end
endmodule
`default_nettype wire

@@ sv/matrix_abbt_plus_ata_engine.sv @@
// Matrix engine computing R = (A*B)*B^T + (A^T*A << FRAC) over a chain of MAX_N
// MAC cells. A read goes through S_FETCH (registered store read) before its result
// is registered on the output. After the last load, compute streams one operand a
// cycle from the element stores into the cell chain.
// Reset (synchronous, rst_n low) clears control state and sets size n to MAX_N;
// the element and result stores are not cleared. Depends on mabt_pkg, mabt_if.
`default_nettype none
module matrix_abbt_plus_ata_engine #(
  parameter int MAX_N        = mabt_pkg::MAX_N_DEF,
  parameter int ELEMENT_BITS = mabt_pkg::ELEMENT_BITS_DEF
) (
  input wire logic  clk,
  input wire logic  rst_n,
  mabt_in_if.sink   in_ch,
  mabt_out_if.source out_ch,
  mabt_cfg_if.sink  cfg_ch
);
  import mabt_pkg::*;
  `include "assert_macros.svh"

  localparam int EB    = ELEMENT_BITS;
  localparam int FRAC  = ELEMENT_BITS / 2;
  localparam int DEPTH = MAX_N * MAX_N;
  localparam int AW    = $clog2(DEPTH);
  localparam int TW    = $clog2(DEPTH + 1);
  localparam int SW    = $clog2(MAX_N + 1);
  localparam int IW    = $clog2(MAX_N);
  localparam int CW    = $clog2(MAX_N + 3);
  localparam int ABW   = 2 * ELEMENT_BITS + $clog2(MAX_N);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_MAC   = 4'b0010,
    S_DRAIN = 4'b0100,
    S_FETCH = 4'b1000
  } state_t;

  typedef enum logic [1:0] {
    PASS_AB    = 2'd0,
    PASS_LEFT  = 2'd1,
    PASS_RIGHT = 2'd2
  } pass_t;

  state_t         state_r, state_nxt;
  pass_t          pass_r, pass_nxt;
  logic [IW-1:0]  row_r, row_nxt;
  logic [IW-1:0]  k_r, k_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic [SW-1:0]  size_r, size_nxt;
  logic [AW-1:0]  load_pos_r, load_pos_nxt;
  logic [AW-1:0]  read_pos_r, read_pos_nxt;
  logic           result_ready_r, result_ready_nxt;
  logic           fetch_last_r, fetch_last_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic [RES_W-1:0] out_value_r, out_value_nxt;
  logic           out_last_r, out_last_nxt;
  logic           out_nodata_r, out_nodata_nxt;
  logic signed [ABW-1:0] x_r, x_nxt;

  logic [TW-1:0]  total;
  logic [TW-1:0]  pos_inc;
  logic [AW-1:0]  pos_eff;
  logic [CW-1:0]  jj_full;
  logic [IW-1:0]  jj;
  logic [CW-1:0]  n_cw;
  logic           in_acc, cfg_acc, out_take;
  logic [6:0]     cfg_raw;
  logic [SW-1:0]  cfg_size;

  logic signed [EB-1:0] a_in_val, b_in_val;
  logic                 a_we, b_we, ab_we, r_we;
  logic [AW-1:0]        a_waddr, a_raddr, b_raddr, ab_raddr, drain_addr;
  logic [EB-1:0]        a_rdata, b_rdata;
  logic [ABW-1:0]       ab_rdata;
  logic [RES_W-1:0]     r_rdata;
  logic signed [EB-1:0] y_feed;
  cell_ctl_t            ctl;

  logic signed [EB-1:0]  y_bus   [MAX_N];
  logic [RES_W-1:0]      acc_bus [MAX_N];

  // flat index of element (r, c) for the active size
  function automatic logic [AW-1:0] idx(input logic [IW-1:0] r, input logic [IW-1:0] c,
                                        input logic [SW-1:0] n);
    idx = AW'(AW'(r) * AW'(n)) + AW'(c);
  endfunction

  assign total   = TW'(TW'(size_r) * TW'(size_r));
  assign pos_eff = result_ready_r ? '0 : load_pos_r;
  assign pos_inc = TW'(pos_eff) + TW'(1);
  assign n_cw    = CW'(size_r);
  assign jj_full = n_cw - cnt_r;
  assign jj      = jj_full[IW-1:0];

  // size writes only while idle and no request is offered
  assign in_ch.ready  = (state_r == S_IDLE) && (!out_valid_r || out_ch.ready);
  assign cfg_ch.ready = (state_r == S_IDLE) && !in_ch.valid;
  assign in_acc   = in_ch.valid && in_ch.ready;
  assign cfg_acc  = cfg_ch.valid && cfg_ch.ready;
  assign out_take = out_valid_r && out_ch.ready;

  assign out_ch.valid        = out_valid_r;
  assign out_ch.result_value = out_value_r;
  assign out_ch.last_element = out_last_r;
  assign out_ch.no_data      = out_nodata_r;

  assign a_in_val = EB'($signed(in_ch.a_element));
  assign b_in_val = EB'($signed(in_ch.b_element));

  // size clamp: zero reads as one, above MAX_N saturates
  assign cfg_raw  = 7'(cfg_ch.size_n);
  assign cfg_size = (cfg_raw == 7'd0) ? SW'(1) :
                    (cfg_raw > 7'(MAX_N)) ? SW'(MAX_N) : SW'(cfg_raw);

  // store addressing
  assign a_we    = in_acc && (in_ch.command == CMD_LOAD);
  assign b_we    = a_we;
  assign a_waddr = pos_eff;
  assign drain_addr = idx(row_r, IW'(cnt_r - CW'(1)), size_r);
  assign ab_we   = (state_r == S_DRAIN) && (cnt_r != '0) && (pass_r == PASS_AB);
  assign r_we    = (state_r == S_DRAIN) && (cnt_r != '0) && (pass_r == PASS_RIGHT);
  assign ab_raddr = idx(row_r, k_r, size_r);
  assign b_raddr  = (pass_r == PASS_AB) ? idx(k_r, jj, size_r) : idx(jj, k_r, size_r);

  always_comb begin
    a_raddr = idx(k_r, jj, size_r);
    if (pass_r == PASS_AB) begin
      a_raddr = idx(row_r, k_r, size_r);
    end else if (cnt_r == '0) begin
      a_raddr = idx(k_r, row_r, size_r);
    end
  end

  mabt_ram #(.WIDTH(EB), .DEPTH(DEPTH)) u_a_store (
    .clk(clk), .we(a_we), .waddr(a_waddr), .wdata(a_in_val),
    .raddr(a_raddr), .rdata(a_rdata)
  );
  mabt_ram #(.WIDTH(EB), .DEPTH(DEPTH)) u_b_store (
    .clk(clk), .we(b_we), .waddr(a_waddr), .wdata(b_in_val),
    .raddr(b_raddr), .rdata(b_rdata)
  );
  mabt_ram #(.WIDTH(ABW), .DEPTH(DEPTH)) u_ab_store (
    .clk(clk), .we(ab_we), .waddr(drain_addr), .wdata(acc_bus[0][ABW-1:0]),
    .raddr(ab_raddr), .rdata(ab_rdata)
  );
  mabt_ram #(.WIDTH(RES_W), .DEPTH(DEPTH)) u_r_store (
    .clk(clk), .we(r_we), .waddr(drain_addr), .wdata(acc_bus[0]),
    .raddr(read_pos_r), .rdata(r_rdata)
  );

  // chain control
  assign y_feed = (pass_r == PASS_RIGHT) ? $signed(a_rdata) : $signed(b_rdata);
  always_comb begin
    ctl           = '0;
    ctl.shl       = (pass_r == PASS_RIGHT);
    ctl.shift_y   = (state_r == S_MAC) && (cnt_r >= CW'(2)) && (cnt_r <= n_cw + CW'(1));
    ctl.mul       = (state_r == S_MAC) && (cnt_r == n_cw + CW'(2));
    ctl.clr       = (state_r == S_MAC) && (cnt_r == '0) && (k_r == '0) &&
                    (pass_r != PASS_RIGHT);
    ctl.shift_acc = (state_r == S_DRAIN) && (cnt_r != '0);
  end

  // cell chain: operands move up, accumulators drain down to cell 0
  for (genvar g = 0; g < MAX_N; g++) begin : g_cell
    logic signed [EB-1:0] y_in_w;
    logic [RES_W-1:0]     acc_in_w;
    if (g == 0) begin : g_first
      assign y_in_w = y_feed;
    end else begin : g_rest
      assign y_in_w = y_bus[g-1];
    end
    if (g == MAX_N - 1) begin : g_top
      assign acc_in_w = '0;
    end else begin : g_mid
      assign acc_in_w = acc_bus[g+1];
    end
    mabt_cell #(.XW(ABW), .YW(EB), .FRAC(FRAC)) u_cell (
      .clk(clk), .rst_n(rst_n), .ctl(ctl), .x(x_r),
      .y_in(y_in_w), .y_out(y_bus[g]),
      .acc_in(acc_in_w), .acc_out(acc_bus[g])
    );
  end

  // sequencer and request handling
  always_comb begin
    state_nxt        = state_r;
    pass_nxt         = pass_r;
    row_nxt          = row_r;
    k_nxt            = k_r;
    cnt_nxt          = cnt_r;
    size_nxt         = size_r;
    load_pos_nxt     = load_pos_r;
    read_pos_nxt     = read_pos_r;
    result_ready_nxt = result_ready_r;
    fetch_last_nxt   = fetch_last_r;
    out_valid_nxt    = out_take ? 1'b0 : out_valid_r;
    out_value_nxt    = out_value_r;
    out_last_nxt     = out_last_r;
    out_nodata_nxt   = out_nodata_r;
    x_nxt            = x_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc && (in_ch.command == CMD_LOAD)) begin
          read_pos_nxt = result_ready_r ? '0 : read_pos_r;
          if (pos_inc == total) begin
            load_pos_nxt     = '0;
            read_pos_nxt     = '0;
            result_ready_nxt = 1'b1;
            state_nxt        = S_MAC;
            pass_nxt         = PASS_AB;
            row_nxt          = '0;
            k_nxt            = '0;
            cnt_nxt          = '0;
          end else begin
            load_pos_nxt     = AW'(pos_inc);
            result_ready_nxt = 1'b0;
          end
        end else if (in_acc) begin
          if (!result_ready_r) begin
            out_valid_nxt  = 1'b1;
            out_value_nxt  = '0;
            out_last_nxt   = 1'b0;
            out_nodata_nxt = 1'b1;
          end else begin
            fetch_last_nxt = (TW'(read_pos_r) + TW'(1) == total);
            state_nxt      = S_FETCH;
            if (TW'(read_pos_r) + TW'(1) == total) begin
              read_pos_nxt     = '0;
              result_ready_nxt = 1'b0;
            end else begin
              read_pos_nxt = read_pos_r + AW'(1);
            end
          end
        end
        if (cfg_acc) begin
          size_nxt         = cfg_size;
          load_pos_nxt     = '0;
          read_pos_nxt     = '0;
          result_ready_nxt = 1'b0;
        end
      end
      S_FETCH: begin
        out_valid_nxt  = 1'b1;
        out_value_nxt  = r_rdata;
        out_last_nxt   = fetch_last_r;
        out_nodata_nxt = 1'b0;
        state_nxt      = S_IDLE;
      end
      S_MAC: begin
        if (cnt_r == CW'(1)) begin
          x_nxt = (pass_r == PASS_LEFT) ? $signed(ab_rdata) : ABW'($signed(a_rdata));
        end
        if (cnt_r == n_cw + CW'(2)) begin
          cnt_nxt = '0;
          if (k_r == IW'(size_r - SW'(1))) begin
            k_nxt = '0;
            case (pass_r)
              PASS_LEFT: pass_nxt  = PASS_RIGHT;
              default:   state_nxt = S_DRAIN;
            endcase
          end else begin
            k_nxt = k_r + IW'(1);
          end
        end else begin
          cnt_nxt = cnt_r + CW'(1);
        end
      end
      S_DRAIN: begin
        if (cnt_r == n_cw) begin
          cnt_nxt = '0;
          if (pass_r == PASS_AB) begin
            pass_nxt  = PASS_LEFT;
            state_nxt = S_MAC;
          end else if (row_r == IW'(size_r - SW'(1))) begin
            pass_nxt  = PASS_AB;
            row_nxt   = '0;
            state_nxt = S_IDLE;
          end else begin
            pass_nxt  = PASS_AB;
            row_nxt   = row_r + IW'(1);
            state_nxt = S_MAC;
          end
        end else begin
          cnt_nxt = cnt_r + CW'(1);
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      pass_r         <= PASS_AB;
      row_r          <= '0;
      k_r            <= '0;
      cnt_r          <= '0;
      size_r         <= SW'(MAX_N);
      load_pos_r     <= '0;
      read_pos_r     <= '0;
      result_ready_r <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      pass_r         <= pass_nxt;
      row_r          <= row_nxt;
      k_r            <= k_nxt;
      cnt_r          <= cnt_nxt;
      size_r         <= size_nxt;
      load_pos_r     <= load_pos_nxt;
      read_pos_r     <= read_pos_nxt;
      result_ready_r <= result_ready_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    fetch_last_r <= fetch_last_nxt;
    out_value_r  <= out_value_nxt;
    out_last_r   <= out_last_nxt;
    out_nodata_r <= out_nodata_nxt;
    x_r          <= x_nxt;
  end

  `MABT_NEVER(a_compute_needs_set, clk, rst_n, (state_r != S_IDLE) && (state_r != S_FETCH) && !result_ready_r)
  `MABT_NEXT(a_fetch_fills_out, clk, rst_n, state_r == S_FETCH, out_valid_r && !out_nodata_r)
  `MABT_IMPL(a_nodata_zero, clk, rst_n, out_valid_r && out_nodata_r, (out_value_r == '0) && !out_last_r)
  `MABT_NEVER(a_load_pos_range, clk, rst_n, TW'(load_pos_r) >= total)
endmodule
`default_nettype wire

@@ test/matrix_abbt_plus_ata_engine_test.sv @@
// Self-checking testbench for matrix_abbt_plus_ata_engine: drives load and read requests
// and size writes, predicts every result in a scoreboard class and compares field by field.
// Depends on mabt_pkg, the mabt channel interfaces and the engine RTL.
module matrix_abbt_plus_ata_engine_test;
  import mabt_pkg::*;

  localparam int  DEPTH     = MAX_N_DEF * MAX_N_DEF;
  localparam int  FRAC      = ELEMENT_BITS_DEF / 2;
  localparam int  HOLD_LEN  = 400;
  localparam longint CYCLE_LIMIT = 2000000;

  typedef struct {
    logic [RES_W-1:0] value;
    logic             last;
    logic             no_data;
  } result_t;

  // predicts R = (A*B)*B^T + (A^T*A << FRAC) per request and holds the results still owed
  class abbt_scoreboard;
    longint    a_mem[DEPTH];
    longint    b_mem[DEPTH];
    longint    r_mem[DEPTH];
    int        load_pos;
    int        read_pos;
    bit        have_result;
    int        size;
    int        errors;
    result_t   owed[$];

    function new();
      load_pos = 0;
      read_pos = 0;
      have_result = 0;
      size = MAX_N_DEF;
      errors = 0;
    endfunction

    function void write_size(logic [SIZE_W-1:0] v);
      size = (v == 0) ? 1 : ((v > MAX_N_DEF) ? MAX_N_DEF : int'(v));
      load_pos = 0;
      read_pos = 0;
      have_result = 0;
    endfunction

    function void multiply();
      longint ab[DEPTH];
      longint lhs, rhs;
      for (int i = 0; i < size; i++)
        for (int j = 0; j < size; j++) begin
          lhs = 0;
          for (int k = 0; k < size; k++) lhs += a_mem[i*size+k] * b_mem[k*size+j];
          ab[i*size+j] = lhs;
        end
      for (int i = 0; i < size; i++)
        for (int j = 0; j < size; j++) begin
          lhs = 0;
          rhs = 0;
          for (int k = 0; k < size; k++) begin
            lhs += ab[i*size+k] * b_mem[j*size+k];
            rhs += a_mem[k*size+i] * a_mem[k*size+j];
          end
          r_mem[i*size+j] = lhs + (rhs <<< FRAC);
        end
    endfunction

    function void note_request(logic cmd, logic [ELEM_W-1:0] a, logic [ELEM_W-1:0] b);
      result_t r;
      int total;
      total = size * size;
      if (cmd == CMD_LOAD) begin
        // a load in the read phase drops what is left and starts afresh
        if (have_result) begin
          have_result = 0;
          read_pos = 0;
          load_pos = 0;
        end
        if (load_pos >= total) load_pos = 0;
        a_mem[load_pos] = longint'($signed(a));
        b_mem[load_pos] = longint'($signed(b));
        load_pos++;
        if (load_pos >= total) begin
          multiply();
          load_pos = 0;
          read_pos = 0;
          have_result = 1;
        end
        return;
      end
      if (!have_result || read_pos >= total) begin
        r.value = '0;
        r.last = 1'b0;
        r.no_data = 1'b1;
      end else begin
        r.value = r_mem[read_pos];
        r.last = (read_pos == total - 1);
        r.no_data = 1'b0;
        read_pos++;
        if (read_pos >= total) begin
          have_result = 0;
          read_pos = 0;
        end
      end
      owed.push_back(r);
    endfunction

    function void check_result(logic [RES_W-1:0] v, logic last, logic nd);
      result_t e;
      if (owed.size() == 0) begin
        $error("result with nothing expected: result_value %h", v);
        errors++;
        return;
      end
      e = owed.pop_front();
      if (v !== e.value) begin
        $error("result_value expected %h actual %h", e.value, v);
        errors++;
      end
      if (last !== e.last) begin
        $error("last_element expected %b actual %b", e.last, last);
        errors++;
      end
      if (nd !== e.no_data) begin
        $error("no_data expected %b actual %b", e.no_data, nd);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  mabt_in_if  in_ch();
  mabt_out_if out_ch();
  mabt_cfg_if cfg_ch();

  matrix_abbt_plus_ata_engine i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  abbt_scoreboard sb;
  int     gap_pct;
  int     stall_pct;
  int     hold_seq;
  int     hold_seen;
  int     hold_left;
  longint cycles;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_seq != hold_seen) begin
      hold_seen <= hold_seq;
      hold_left <= HOLD_LEN;
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // result check
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result(out_ch.result_value, out_ch.last_element, out_ch.no_data);
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("matrix_abbt_plus_ata_engine test failed");
      $finish;
    end
  end

  // one request, held until accepted; an optional gap goes before it
  task automatic send(logic cmd, logic [ELEM_W-1:0] a, logic [ELEM_W-1:0] b);
    if ($urandom_range(0, 99) < gap_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.command <= cmd;
    in_ch.a_element <= a;
    in_ch.b_element <= b;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_request(cmd, a, b);
  endtask

  function automatic logic [ELEM_W-1:0] pick_element();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'hffff;
      default: return ELEM_W'($urandom);
    endcase
  endfunction

  // wait until every result is back and any compute pass has finished
  task automatic drain();
    int n;
    in_ch.valid <= 1'b0;
    while (sb.owed.size() != 0) @(posedge clk);
    n = sb.size;
    repeat (n * (3*n*(n+3) + 2*(n+1)) + 40) @(posedge clk);
  endtask

  task automatic write_size(logic [SIZE_W-1:0] v);
    drain();
    cfg_ch.valid <= 1'b1;
    cfg_ch.size_n <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    sb.write_size(v);
  endtask

  // random sets: mostly whole load/read sequences, some broken ones and noise
  task automatic random_sets(int target);
    int start;
    int total;
    int kind;
    int n_ld;
    int n_rd;
    start = 0;
    while (start < target) begin
      total = sb.size * sb.size;
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
        n_ld = total;
        n_rd = total + $urandom_range(0, 2);
      end else if (kind == 7) begin
        n_ld = $urandom_range(1, total);
        n_rd = $urandom_range(1, 3);
      end else if (kind == 8) begin
        n_ld = total;
        n_rd = $urandom_range(0, total - 1);
      end else begin
        n_ld = 0;
        n_rd = 0;
        repeat (5) send(logic'($urandom_range(0, 1)), pick_element(), pick_element());
        start += 5;
      end
      repeat (n_ld) send(CMD_LOAD, pick_element(), pick_element());
      repeat (n_rd) send(CMD_READ, pick_element(), pick_element());
      start += n_ld + n_rd;
    end
  endtask

  task automatic phase(logic [SIZE_W-1:0] sz, int gap, int stall, int target);
    write_size(sz);
    gap_pct = gap;
    stall_pct = stall;
    random_sets(target);
  endtask

  initial begin
    sb = new();
    gap_pct = 0;
    stall_pct = 0;
    hold_seq = 0;
    hold_seen = 0;
    hold_left = 0;
    cycles = 0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.command = CMD_LOAD;
    in_ch.a_element = '0;
    in_ch.b_element = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.size_n = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: read with nothing loaded, size extremes, element extremes
    send(CMD_READ, 16'h0000, 16'h0000);
    write_size(5'd17);
    write_size(5'd1);
    send(CMD_LOAD, 16'h8000, 16'h8000);
    send(CMD_READ, 16'h0000, 16'h0000);
    send(CMD_READ, 16'h0000, 16'h0000);
    send(CMD_LOAD, 16'h7fff, 16'h7fff);
    send(CMD_LOAD, 16'h8000, 16'h7fff);
    send(CMD_READ, 16'hffff, 16'hffff);
    write_size(5'd0);
    send(CMD_LOAD, 16'h7fff, 16'h8000);
    send(CMD_READ, 16'h0000, 16'h0000);
    write_size(5'd2);
    send(CMD_LOAD, 16'h8000, 16'h0100);
    send(CMD_READ, 16'h0000, 16'h0000);
    send(CMD_LOAD, 16'h7fff, 16'hff00);
    send(CMD_LOAD, 16'h0001, 16'hffff);
    send(CMD_LOAD, 16'hffff, 16'h8000);
    send(CMD_READ, 16'h0000, 16'h0000);
    send(CMD_READ, 16'h0000, 16'h0000);
    // load in the read phase discards the rest
    send(CMD_LOAD, 16'h0100, 16'h0100);
    send(CMD_READ, 16'h0000, 16'h0000);

    // random phases over the idling patterns
    phase(5'd2, 0, 0, 350);
    phase(5'd0, 56, 0, 250);
    phase(5'd3, 0, 56, 350);
    phase(5'd8, 8, 8, 350);
    phase(5'd31, 0, 0, 520);

    // long receiver hold-off while reads keep coming
    write_size(5'd1);
    gap_pct = 0;
    stall_pct = 0;
    send(CMD_LOAD, pick_element(), pick_element());
    drain();
    hold_seq = hold_seq + 1;
    repeat (60) send(CMD_READ, 16'h0000, 16'h0000);

    drain();
    if (sb.errors == 0) begin
      $display("matrix_abbt_plus_ata_engine test passed");
    end else begin
      $display("matrix_abbt_plus_ata_engine test failed");
    end
    $finish;
  end
endmodule
